>>> rtl/lzw_pc_pkg.sv
// Shared constants and types for the LZW phrase counter.
`timescale 1ns / 1ps
`default_nettype none

package lzw_pc_pkg;

  // Dictionary size in nodes and letters per node.
  localparam int DICT_NODES = 4096;
  localparam int ALPHABET   = 26;

  // Derived widths. SYM_IDX_W must not exceed SYM_W (the symbol port width).
  localparam int NODE_W     = $clog2(DICT_NODES);
  localparam int FREE_W     = NODE_W + 1;
  localparam int SYM_W      = 5;
  localparam int SYM_IDX_W  = $clog2(ALPHABET);
  localparam int CNT_W      = 12;
  localparam int FIRST_FREE = ALPHABET + 2;
  localparam int COUNT_MAX  = (1 << CNT_W) - 1;
  localparam int ROW_W      = ALPHABET * NODE_W;

  // One trie row: a child slot per letter, zero means empty.
  typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

  // Control sequencer.
  typedef enum logic {
    ST_READY,
    ST_LOOKUP
  } state_t;

  // One result item as held in the output queue.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/lzw_phrase_counter.sv
// Top level of the LZW phrase counter: trie walk over a row-wide RAM.
//
// Input channel (in_valid / in_stall) carries one letter code per transfer
// with first and last marks. first starts a new run: empty dictionary, count
// one. Codes outside the alphabet leave the trie untouched. Each item with
// last set produces one result transfer on the output channel (out_valid /
// out_stall): the phrase count and the overflow flag of the current run.
// The trie lives in one RAM, one row per node, one child slot per letter.
// A symbol that walks the trie reads its row in the accept cycle, then
// makes the hit/miss decision and write-back in the lookup state. Items that
// start at the root or carry an out-of-range code need no lookup. Results are
// registered in the result queue. Root rows carry valid bits that first
// clears; a newly allocated node's row is zeroed by a write in the cycle
// after its allocation, so no clearing pass is needed at reset or per run.
// A two-entry result queue keeps taking input while a result waits; input
// stalls only when the queue is full or a lookup is in flight.
// Synchronous reset returns the block to an empty run with no results queued.
`timescale 1ns / 1ps
`default_nettype none

module lzw_phrase_counter
  import lzw_pc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic             first,
  input  wire logic             last,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [CNT_W-1:0]      phrase_count,
  output logic                  overflow
);

  // Run state
  logic [NODE_W-1:0]    current_node;
  logic [FREE_W-1:0]    next_free_node;
  logic [CNT_W-1:0]     count_reg;
  logic                 full_flag;
  logic [ALPHABET-1:0]  root_valid;
  state_t               state, state_next;

  // Item held across the lookup
  logic [SYM_IDX_W-1:0] sym_q;
  logic                 last_q;

  // Deferred zeroing of a freshly allocated row
  logic                 clr_pend;
  logic [NODE_W-1:0]    clr_addr;

  // Result queue
  result_t              q0, q1;
  logic [1:0]           q_cnt;

  // Handshake and accept-cycle values
  logic                 accept, lookup_cyc, q_full;
  logic                 sym_ok, need_lookup;
  logic [NODE_W-1:0]    cur_eff, root_node;
  logic [FREE_W-1:0]    free_eff;
  logic [CNT_W-1:0]     count_eff;
  logic                 full_eff;
  logic [ALPHABET-1:0]  rv_eff;

  // Lookup-cycle values
  logic [ROW_W-1:0]     rd_data;
  row_t                 row_view, row_new;
  logic                 is_root;
  logic [SYM_IDX_W-1:0] root_idx;
  logic [NODE_W-1:0]    child, sym_root;
  logic                 hit, room, alloc;
  logic [CNT_W-1:0]     count_inc;

  // RAM ports
  logic                 wr_en;
  logic [NODE_W-1:0]    wr_addr;
  logic [ROW_W-1:0]     wr_data;

  // Result push
  logic                 push, pop;
  result_t              res;

  assign accept = in_valid && !in_stall;

  // Run state as seen by the accepted item (first clears it)
  assign cur_eff     = first ? '0 : current_node;
  assign free_eff    = first ? FREE_W'(FIRST_FREE) : next_free_node;
  assign count_eff   = first ? CNT_W'(1) : count_reg;
  assign full_eff    = first ? 1'b0 : full_flag;
  assign rv_eff      = first ? '0 : root_valid;
  assign sym_ok      = int'(symbol) < ALPHABET;
  assign root_node   = NODE_W'(symbol) + NODE_W'(1);
  assign need_lookup = accept && sym_ok && (cur_eff != '0);

  // Row view: an unwritten root row reads as empty
  assign is_root  = current_node <= NODE_W'(ALPHABET);
  assign root_idx = SYM_IDX_W'(current_node - NODE_W'(1));
  always_comb begin
    row_view = row_t'(rd_data);
    if (is_root && !root_valid[root_idx]) begin
      row_view = '0;
    end
    row_new        = row_view;
    row_new[sym_q] = next_free_node[NODE_W-1:0];
  end

  // Hit/miss decision
  assign child     = row_view[sym_q];
  assign hit       = child != '0;
  assign room      = next_free_node < FREE_W'(DICT_NODES);
  assign alloc     = lookup_cyc && !hit && room;
  assign sym_root  = NODE_W'(sym_q) + NODE_W'(1);
  assign count_inc = (count_reg == CNT_W'(COUNT_MAX)) ? count_reg : count_reg + CNT_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_READY:  if (need_lookup) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_READY;
      default:   state_next = ST_READY;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    lookup_cyc = 1'b0;
    unique case (state)
      ST_READY:  lookup_cyc = 1'b0;
      ST_LOOKUP: lookup_cyc = 1'b1;
      default:   lookup_cyc = 1'b0;
    endcase
  end

  assign q_full   = q_cnt == 2'd2;
  assign in_stall = lookup_cyc || q_full;

  // Run state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_READY;
      current_node   <= '0;
      next_free_node <= FREE_W'(FIRST_FREE);
      count_reg      <= CNT_W'(1);
      full_flag      <= 1'b0;
      root_valid     <= '0;
      clr_pend       <= 1'b0;
    end else begin
      state    <= state_next;
      clr_pend <= alloc;
      if (accept) begin
        current_node   <= (sym_ok && cur_eff == '0) ? root_node : cur_eff;
        next_free_node <= free_eff;
        count_reg      <= count_eff;
        full_flag      <= full_eff;
        root_valid     <= rv_eff;
      end else if (lookup_cyc) begin
        current_node <= hit ? child : sym_root;
        if (alloc) begin
          next_free_node <= next_free_node + FREE_W'(1);
          count_reg      <= count_inc;
          if (is_root) begin
            root_valid[root_idx] <= 1'b1;
          end
        end else if (!hit) begin
          full_flag <= 1'b1;
        end
      end
    end
  end

  // Item payload and pending clear address
  always_ff @(posedge clk) begin
    if (accept) begin
      sym_q  <= symbol[SYM_IDX_W-1:0];
      last_q <= last;
    end
    if (alloc) begin
      clr_addr <= next_free_node[NODE_W-1:0];
    end
  end

  // Write port: new child on a miss, else zero the row allocated last cycle
  assign wr_en   = alloc || clr_pend;
  assign wr_addr = alloc ? current_node : clr_addr;
  assign wr_data = alloc ? ROW_W'(row_new) : '0;

  lzw_pc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DICT_NODES)
  ) u_trie (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (need_lookup),
    .rd_addr (cur_eff),
    .rd_data (rd_data)
  );

  // Result source: accept cycle for root/invalid items, else lookup cycle
  always_comb begin
    push = 1'b0;
    res  = '{count: count_eff, ovf: full_eff};
    if (lookup_cyc) begin
      push = last_q;
      res  = '{count: alloc ? count_inc : count_reg, ovf: full_flag || (!hit && !room)};
    end else if (accept && last && !need_lookup) begin
      push = 1'b1;
    end
  end

  // Two-entry result queue, head drives the output
  assign out_valid    = q_cnt != 2'd0;
  assign pop          = out_valid && !out_stall;
  assign phrase_count = q0.count;
  assign overflow     = q0.ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (q_cnt == 2'd0) begin
          q0 <= res;
        end else begin
          q1 <= res;
        end
      end
      2'b11: begin
        if (q_cnt == 2'd1) begin
          q0 <= res;
        end else begin
          q0 <= q1;
          q1 <= res;
        end
      end
      2'b01: q0 <= q1;
      default: q0 <= q0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/lzw_pc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module lzw_pc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lzw_pc_checker.sv
// Port-level checks for the LZW phrase counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lzw_pc_checker
  import lzw_pc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic [SYM_W-1:0] symbol,
  input wire logic             first,
  input wire logic             last,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [CNT_W-1:0] phrase_count,
  input wire logic             overflow
);

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Count is always at least one
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> phrase_count != '0)
    else $error("zero phrase count");

  // A single-item run reports count one without overflow on the next cycle
  a_single_run: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && first && last && !out_valid |=>
      out_valid && phrase_count == CNT_W'(1) && !overflow)
    else $error("single-item run gave wrong result");

  // An accepted symbol is never unknown
  a_sym_known: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !$isunknown(symbol))
    else $error("unknown symbol accepted");

endmodule

bind lzw_phrase_counter lzw_pc_checker u_lzw_pc_checker (.*);

`default_nettype wire

>>> sim/tb_lzw_phrase_counter.sv
// Self-checking testbench for the LZW phrase counter.
`timescale 1ns / 1ps

module tb_lzw_phrase_counter
  import lzw_pc_pkg::*;
();

  localparam int LIMIT      = 1000000;  // cycle budget for the whole run
  localparam int HOLD_AT    = 200;      // transfers taken before the long receiver hold
  localparam int HOLD_LEN   = 300;      // cycles of the long receiver hold
  localparam int CALM_ITEMS = 150;      // tail of the run with no idling
  localparam int TRIE_ROWS  = DICT_NODES + ALPHABET + 2;

  // One input letter as queued for the driver.
  typedef struct {
    logic [SYM_W-1:0] sym;
    logic             first;
    logic             last;
  } letter_t;

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [SYM_W-1:0] symbol    = '0;
  logic             first     = 1'b0;
  logic             last      = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CNT_W-1:0] phrase_count;
  logic             overflow;

  lzw_phrase_counter i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .symbol       (symbol),
    .first        (first),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .phrase_count (phrase_count),
    .overflow     (overflow)
  );

  // Stimulus and expectation stores.
  letter_t letter_q[$];
  result_t tally_q[$];
  letter_t next_letter;
  letter_t seen_letter;
  result_t seen_tally;
  result_t want_tally;

  int  queued_cnt  = 0;
  int  taken_cnt   = 0;
  int  fail_cnt    = 0;
  int  cycle_cnt   = 0;
  int  send_gap    = 0;
  int  stall_run   = 0;
  int  hold_cycles = 0;
  bit  hold_done   = 1'b0;
  bit  stim_done   = 1'b0;
  bit  in_fire     = 1'b0;

  // Shadow copy of the trie walk.
  logic [NODE_W-1:0] trie_slot [int];
  int unsigned       walk_node  = 0;
  int unsigned       free_node  = FIRST_FREE;
  int unsigned       phrase_cnt = 1;
  bit                dict_full  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the shadow trie by one letter; returns 1 when a count is reported.
  function automatic bit count_phrases(input letter_t it, output result_t res);
    int key;
    if (it.first) begin
      trie_slot.delete();
      walk_node  = 0;
      free_node  = FIRST_FREE;
      phrase_cnt = 1;
      dict_full  = 1'b0;
    end
    if (it.sym < ALPHABET) begin
      if (walk_node == 0 || walk_node >= TRIE_ROWS) begin
        walk_node = it.sym + 1;
      end else begin
        key = walk_node * ALPHABET + it.sym;
        if (trie_slot.exists(key)) begin
          walk_node = trie_slot[key];
        end else begin
          // miss: add the phrase if there is room, restart at the letter
          if (free_node < DICT_NODES) begin
            trie_slot[key] = NODE_W'(free_node);
            free_node++;
            if (phrase_cnt < COUNT_MAX) phrase_cnt++;
          end else begin
            dict_full = 1'b1;
          end
          walk_node = it.sym + 1;
        end
      end
    end
    res.count = CNT_W'(phrase_cnt);
    res.ovf   = dict_full;
    return it.last;
  endfunction

  task automatic queue_letter(input int sym, input bit fst, input bit lst);
    letter_t it;
    it.sym   = SYM_W'(sym);
    it.first = fst;
    it.last  = lst;
    letter_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_cnt, what, want, got);
  endtask

  // Random runs: mostly new runs, some continuing the previous one, narrow
  // alphabets now and then so that the walk goes deep.
  task automatic queue_random_runs(input int n_items);
    int done_items;
    int run_len;
    int alpha_hi;
    int sym;
    bit fst;
    bit lst;
    done_items = 0;
    while (done_items < n_items) begin
      run_len  = ($urandom_range(9) == 0) ? $urandom_range(300, 150) : $urandom_range(40, 1);
      fst      = ($urandom_range(5) != 0);
      case ($urandom_range(3))
        0: alpha_hi = 1;
        1: alpha_hi = 3;
        default: alpha_hi = ALPHABET - 1;
      endcase
      for (int j = 0; j < run_len; j++) begin
        if ($urandom_range(19) == 0) sym = $urandom_range(31, ALPHABET);
        else sym = $urandom_range(alpha_hi, 0);
        lst = (j == run_len - 1) || ($urandom_range(11) == 0);
        queue_letter(sym, fst && (j == 0), lst);
      end
      done_items += run_len;
    end
  endtask

  // One long run: every letter pair first, then three-letter phrases, each
  // costing a hit and a miss, so that the trie grows several levels deep.
  task automatic queue_deep_run();
    bit pair_used [ALPHABET][ALPHABET];
    int next_trip [ALPHABET];
    int prev;
    int pick;
    int b;
    int c;
    bit stuck;
    prev  = 0;
    stuck = 1'b0;
    queue_letter(0, 1'b1, 1'b0);
    // prefer-largest walk over all letter pairs
    while (!stuck) begin
      pick = -1;
      for (int s = ALPHABET - 1; s >= 0; s--)
        if (pick < 0 && !pair_used[prev][s]) pick = s;
      if (pick < 0) begin
        stuck = 1'b1;
      end else begin
        pair_used[prev][pick] = 1'b1;
        queue_letter(pick, 1'b0, 1'b0);
        prev = pick;
      end
    end
    queue_letter(ALPHABET, 1'b0, 1'b1);
    // three-letter phrases from the current letter
    for (int k = 0; k < 150; k++) begin
      if (next_trip[prev] < ALPHABET * ALPHABET) begin
        b = next_trip[prev] % ALPHABET;
        c = next_trip[prev] / ALPHABET;
        next_trip[prev]++;
      end else begin
        b = $urandom_range(ALPHABET - 1);
        c = $urandom_range(ALPHABET - 1);
      end
      queue_letter(b, 1'b0, 1'b0);
      queue_letter(c, 1'b0, (k % 50) == 49);
      prev = c;
    end
    queue_letter(3, 1'b0, 1'b1);
  endtask

  // Sender: new item at the falling edge once the previous one is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (letter_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!(stim_done && letter_q.size() < CALM_ITEMS) &&
                     ((cycle_cnt >> 8) % 3 != 0) && $urandom_range(7) == 0) begin
          send_gap = $urandom_range(5);
          in_valid <= 1'b0;
        end else begin
          next_letter = letter_q.pop_front();
          in_valid <= 1'b1;
          symbol   <= next_letter.sym;
          first    <= next_letter.first;
          last     <= next_letter.last;
        end
      end
    end
  end

  // Receiver stall: short bursts plus one long hold.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (!hold_done && taken_cnt >= HOLD_AT) begin
        hold_done   = 1'b1;
        hold_cycles = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (!(stim_done && letter_q.size() < CALM_ITEMS) &&
                   ((cycle_cnt >> 8) % 3 != 1) && $urandom_range(5) == 0) begin
        stall_run = $urandom_range(5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on each input transfer, check each result transfer.
  always @(posedge clk) begin
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      taken_cnt++;
      seen_letter.sym   = symbol;
      seen_letter.first = first;
      seen_letter.last  = last;
      if (count_phrases(seen_letter, seen_tally)) tally_q.push_back(seen_tally);
    end
    if (!rst && out_valid && !out_stall) begin
      if (tally_q.size() == 0) begin
        note_mismatch("unexpected result, phrase_count", 0, phrase_count);
      end else begin
        want_tally = tally_q.pop_front();
        if (phrase_count !== want_tally.count)
          note_mismatch("phrase_count", want_tally.count, phrase_count);
        if (overflow !== want_tally.ovf)
          note_mismatch("overflow", want_tally.ovf, overflow);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: continue from reset, single-item runs, codes out of range,
    // hit and miss, repeated last, every symbol bit
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(1, 1'b0, 1'b1);
    queue_letter(25, 1'b1, 1'b1);
    queue_letter(26, 1'b1, 1'b1);
    queue_letter(31, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b1);
    queue_letter(31, 1'b0, 1'b1);
    queue_letter(25, 1'b0, 1'b0);
    queue_letter(25, 1'b0, 1'b1);
    queue_letter(16, 1'b1, 1'b0);
    queue_letter(15, 1'b0, 1'b1);
    queue_letter(8, 1'b0, 1'b1);
    queue_letter(4, 1'b0, 1'b1);
    queue_letter(2, 1'b0, 1'b0);
    queue_letter(1, 1'b0, 1'b1);
    queue_letter(30, 1'b1, 1'b0);
    queue_letter(3, 1'b0, 1'b1);

    // sender pauses until every result has drained
    while (taken_cnt != queued_cnt || tally_q.size() != 0) @(posedge clk);

    queue_random_runs(350);
    queue_deep_run();
    queue_random_runs(350);
    stim_done = 1'b1;

    while (taken_cnt != queued_cnt || tally_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> lzw_phrase_counter.f
rtl/lzw_pc_pkg.sv
rtl/lzw_pc_ram.sv
rtl/lzw_phrase_counter.sv
rtl/lzw_pc_checker.sv
sim/tb_lzw_phrase_counter.sv
